// ===== rtl/core/generational_handle_allocator_unit_assert.svh =====
// Assertion macros for the generational handle allocator.
// Used by the top level; the checks sample on clk and are held off while rst is high.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GHA_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("allocator check failed in the same cycle");
`define GHA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("allocator check failed one cycle later");
`else
`define GHA_ASSERT_IMP(label, pre, post)
`define GHA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/core/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
// No dependencies; imported by the top level.
package gha_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = IDX_W + 1;
  localparam int GEN_W = 32;
  localparam int WORD_W = 32;
  localparam int WORD_COUNT = SLOT_COUNT / WORD_W;
  localparam int WADDR_W = $clog2(WORD_COUNT);
  localparam int BIT_W = $clog2(WORD_W);

  localparam logic [2:0] CMD_SPAWN = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_CHECK = 3'd2;
  localparam logic [2:0] CMD_UNDO_SPAWN = 3'd3;
  localparam logic [2:0] CMD_REDO_SPAWN = 3'd4;
  localparam logic [2:0] CMD_UNDO_DESTROY = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1024);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC
  } state_t;

endpackage

// ===== rtl/core/gha_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the generation store and the alive bitmap.
module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/generational_handle_allocator_unit.sv =====
// Top level of the generational handle allocator.
// Depends on gha_pkg, gha_ram and generational_handle_allocator_unit_assert.svh.
//
// Commands arrive on the s_t* stream, one transaction per command, and each
// produces exactly one result transaction on the m_t* stream. s_tuser carries
// the command code; m_tuser carries the status. The user writes capacity_limit
// through cfg_wr_en and cfg_wr_data only while the block is idle; the block
// does not enforce this. Slot generations live in a 1024 x 32 RAM and alive
// bits in a 32 x 32 RAM, with a 32-bit register marking the words that hold
// a free slot. A spawn passes through the S_SCAN, S_READ and S_EXEC states:
// S_SCAN reads the bitmap word of the lowest marked word, S_READ reads the
// chosen slot, and S_EXEC updates the RAMs. Every other command skips S_SCAN,
// since no bitmap search is needed. The result is registered as S_EXEC ends.
// After reset a clearing pass zeroes the alive bitmap; s_tready stays low
// during it. Generations need no clearing, since a slot is always written
// when it is appended.
// A finished result waits in an output register; the next command is still
// accepted, and its update phase waits until m_tready frees the register.
`include "generational_handle_allocator_unit_assert.svh"

module generational_handle_allocator_unit
  import gha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  // handle_index [9:0], handle_generation [41:10], appended_flag [42], zero [47:43]
  input  logic [47:0]      s_tdata,
  // command [2:0]
  input  logic [2:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // result_index [9:0], result_generation [41:10], was_appended [42],
  // handle_alive [43], zero [47:44]
  output logic [47:0]      m_tdata,
  // status [1:0]
  output logic [1:0]       m_tuser
);

  state_t state, state_next;

  logic [2:0]            cmd;
  logic [IDX_W-1:0]      idx;
  logic [GEN_W-1:0]      hgen;
  logic                  app;
  logic [CNT_W-1:0]      used_count;
  logic [CNT_W-1:0]      capacity_limit;
  logic [WORD_COUNT-1:0] summary;
  logic [WADDR_W-1:0]    clear_addr;
  logic [WADDR_W-1:0]    scan_word;
  logic                  scan_hit;
  logic [IDX_W-1:0]      target;
  logic                  found;

  logic [IDX_W-1:0]  out_index;
  logic [GEN_W-1:0]  out_generation;
  logic              out_appended;
  logic              out_alive;
  logic [1:0]        out_status;

  logic               alive_we;
  logic [WADDR_W-1:0] alive_waddr;
  logic [WORD_W-1:0]  alive_wdata;
  logic               alive_re;
  logic [WADDR_W-1:0] alive_raddr;
  logic [WORD_W-1:0]  alive_rdata;
  logic               gen_we;
  logic [IDX_W-1:0]   gen_waddr;
  logic [GEN_W-1:0]   gen_wdata;
  logic               gen_re;
  logic [IDX_W-1:0]   gen_raddr;
  logic [GEN_W-1:0]   gen_rdata;

  logic [WADDR_W-1:0] sum_word;
  logic               any_sum;
  logic [BIT_W-1:0]   zero_bit;
  logic               has_zero;
  logic [IDX_W-1:0]   cand;
  logic               cand_found;
  logic [IDX_W-1:0]   spawn_target;
  logic [IDX_W-1:0]   alive_slot;
  logic [CNT_W-1:0]   dec_count;

  logic             exec_fire;
  logic             in_use;
  logic             alive_bit;
  logic             hok;
  logic [CNT_W-1:0] limit;
  logic             alive_wr;
  logic             alive_new;
  logic             gen_wr;
  logic [GEN_W-1:0] gen_new;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] r_idx;
  logic [GEN_W-1:0] r_gen;
  logic             r_app;
  logic             r_alive;
  logic [1:0]       r_st;
  logic [WORD_W-1:0] word_mod;

  gha_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT)) u_alive_ram (
    .clk   (clk),
    .we    (alive_we),
    .waddr (alive_waddr),
    .wdata (alive_wdata),
    .re    (alive_re),
    .raddr (alive_raddr),
    .rdata (alive_rdata)
  );

  gha_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  always_comb begin
    sum_word = '0;
    any_sum = 1'b0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (summary[i]) begin
        sum_word = WADDR_W'(i);
        any_sum = 1'b1;
      end
    end
  end

  always_comb begin
    zero_bit = '0;
    has_zero = 1'b0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!alive_rdata[i]) begin
        zero_bit = BIT_W'(i);
        has_zero = 1'b1;
      end
    end
  end

  assign dec_count = used_count - CNT_W'(1);
  assign cand = {scan_word, zero_bit};
  assign cand_found = scan_hit && has_zero && ({1'b0, cand} < used_count);
  assign spawn_target = cand_found ? cand : used_count[IDX_W-1:0];

  always_comb begin
    if (cmd == CMD_SPAWN) begin
      alive_slot = spawn_target;
    end else if (cmd == CMD_UNDO_SPAWN && app) begin
      alive_slot = dec_count[IDX_W-1:0];
    end else begin
      alive_slot = idx;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clear_addr == WADDR_W'(WORD_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == CMD_SPAWN) ? S_SCAN : S_READ;
        end
      end
      S_SCAN: state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (exec_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    alive_re = 1'b0;
    gen_re = 1'b0;
    alive_raddr = alive_slot[IDX_W-1:BIT_W];
    gen_raddr = (cmd == CMD_SPAWN) ? spawn_target : idx;
    unique case (state)
      S_CLEAR: ;
      S_IDLE: s_tready = 1'b1;
      S_SCAN: begin
        alive_re = 1'b1;
        alive_raddr = sum_word;
      end
      S_READ: begin
        alive_re = 1'b1;
        gen_re = 1'b1;
      end
      S_EXEC: ;
      default: ;
    endcase
  end

  assign exec_fire = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign limit = (capacity_limit > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : capacity_limit;
  assign in_use = {1'b0, idx} < used_count;
  assign alive_bit = alive_rdata[target[BIT_W-1:0]];
  assign hok = (hgen != '0) && in_use && alive_bit && (gen_rdata == hgen);

  always_comb begin
    alive_wr = 1'b0;
    alive_new = 1'b0;
    gen_wr = 1'b0;
    gen_new = hgen;
    count_next = used_count;
    r_idx = idx;
    r_gen = '0;
    r_app = 1'b0;
    r_alive = 1'b0;
    r_st = ST_OK;
    unique case (cmd)
      CMD_SPAWN: begin
        if (found) begin
          alive_wr = 1'b1;
          alive_new = 1'b1;
          r_idx = target;
          r_gen = gen_rdata;
        end else if (used_count >= limit) begin
          r_st = ST_FULL;
          r_idx = '0;
        end else begin
          alive_wr = 1'b1;
          alive_new = 1'b1;
          gen_wr = 1'b1;
          gen_new = GEN_W'(1);
          count_next = used_count + CNT_W'(1);
          r_idx = target;
          r_gen = GEN_W'(1);
          r_app = 1'b1;
        end
      end
      CMD_DESTROY: begin
        if (hok) begin
          alive_wr = 1'b1;
          gen_wr = 1'b1;
          gen_new = (gen_rdata == '1) ? GEN_W'(1) : gen_rdata + GEN_W'(1);
        end else begin
          r_st = ST_STALE;
        end
      end
      CMD_CHECK: r_alive = hok;
      CMD_UNDO_SPAWN: begin
        if (app) begin
          if (used_count == '0) begin
            r_st = ST_STALE;
          end else begin
            count_next = dec_count;
            alive_wr = 1'b1;
          end
        end else if (in_use && hgen != '0) begin
          alive_wr = 1'b1;
          gen_wr = 1'b1;
        end else begin
          r_st = ST_STALE;
        end
      end
      CMD_REDO_SPAWN: begin
        if (app) begin
          if ({1'b0, idx} != used_count || hgen == '0) begin
            r_st = ST_STALE;
          end else if (used_count >= CNT_W'(SLOT_COUNT)) begin
            r_st = ST_FULL;
          end else begin
            gen_wr = 1'b1;
            alive_wr = 1'b1;
            alive_new = 1'b1;
            count_next = used_count + CNT_W'(1);
          end
        end else if (in_use) begin
          alive_wr = 1'b1;
          alive_new = 1'b1;
        end else begin
          r_st = ST_STALE;
        end
      end
      CMD_UNDO_DESTROY: begin
        if (in_use && hgen != '0) begin
          gen_wr = 1'b1;
          alive_wr = 1'b1;
          alive_new = 1'b1;
        end else begin
          r_st = ST_STALE;
        end
      end
      default: ;
    endcase
    if (cmd != CMD_SPAWN) begin
      r_gen = ({1'b0, idx} < count_next) ? (gen_wr ? gen_new : gen_rdata) : '0;
    end
  end

  always_comb begin
    word_mod = alive_rdata;
    word_mod[target[BIT_W-1:0]] = alive_new;
  end

  always_comb begin
    if (state == S_CLEAR) begin
      alive_we = 1'b1;
      alive_waddr = clear_addr;
      alive_wdata = '0;
    end else begin
      alive_we = exec_fire && alive_wr;
      alive_waddr = target[IDX_W-1:BIT_W];
      alive_wdata = word_mod;
    end
  end

  assign gen_we = exec_fire && gen_wr;
  assign gen_waddr = (cmd == CMD_SPAWN) ? target : idx;
  assign gen_wdata = gen_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_addr <= '0;
      used_count <= '0;
      capacity_limit <= CAPACITY_RESET;
      summary <= '1;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + WADDR_W'(1);
      end
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
      if (alive_we) begin
        summary[alive_waddr] <= ~&alive_wdata;
      end
      if (exec_fire) begin
        used_count <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= s_tuser;
      idx <= s_tdata[IDX_W-1:0];
      hgen <= s_tdata[IDX_W+GEN_W-1:IDX_W];
      app <= s_tdata[IDX_W+GEN_W];
    end
    if (state == S_SCAN) begin
      scan_word <= sum_word;
      scan_hit <= any_sum;
    end
    if (state == S_READ) begin
      target <= alive_slot;
      found <= cand_found;
    end
    if (exec_fire) begin
      out_index <= r_idx;
      out_generation <= r_gen;
      out_appended <= r_app;
      out_alive <= r_alive;
      out_status <= r_st;
    end
  end

  assign m_tdata = {4'b0, out_alive, out_appended, out_generation, out_index};
  assign m_tuser = out_status;

  `GHA_ASSERT_IMP(a_count_bound, 1'b1, used_count <= CNT_W'(SLOT_COUNT))
  `GHA_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state == S_SCAN || state == S_READ)
  `GHA_ASSERT_NEXT(a_full_keeps_count, exec_fire && r_st == ST_FULL, $stable(used_count))
  `GHA_ASSERT_NEXT(a_append_grows, exec_fire && r_app, used_count == $past(used_count) + CNT_W'(1))

endmodule

// ===== dv/handle_allocator_checker.sv =====
`timescale 1ns / 1ps
// Checker for the generational handle allocator: watches the configuration port and both streams.
// It keeps its own slot table, predicts each result and compares it field by field.
// Depends on gha_pkg.
module handle_allocator_checker
  import gha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [47:0]      s_tdata,
  input  logic [2:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [47:0]      m_tdata,
  input  logic [1:0]       m_tuser,
  output int               error_count,
  output int               pending_results
);

  typedef struct {
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] generation;
    logic             appended;
    logic             alive;
    logic [1:0]       status;
  } handle_result_t;

  logic [GEN_W-1:0] gen_table [SLOT_COUNT];
  logic             live_bits [SLOT_COUNT];
  int unsigned      slots_used;
  logic [CNT_W-1:0] cap_setting;
  handle_result_t   expected_results [$];
  handle_result_t   want;
  int               mismatch_total = 0;
  int               n;

  assign error_count = mismatch_total;

  function automatic bit handle_valid(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    return gen != '0 && idx < slots_used && live_bits[idx] && gen_table[idx] == gen;
  endfunction

  function automatic handle_result_t apply_command(logic [2:0] cmd, logic [IDX_W-1:0] idx,
                                                   logic [GEN_W-1:0] gen, logic app);
    handle_result_t r;
    int unsigned    limit;
    int             free_slot;
    bit             show_slot;
    r.slot = idx;
    r.generation = '0;
    r.appended = 1'b0;
    r.alive = 1'b0;
    r.status = ST_OK;
    show_slot = 1'b1;
    case (cmd)
      CMD_SPAWN: begin
        show_slot = 1'b0;
        limit = (cap_setting < SLOT_COUNT) ? cap_setting : SLOT_COUNT;
        free_slot = -1;
        for (int k = 0; k < slots_used; k++) begin
          if (!live_bits[k] && free_slot < 0) free_slot = k;
        end
        if (free_slot >= 0) begin
          live_bits[free_slot] = 1'b1;
          r.slot = free_slot[IDX_W-1:0];
          r.generation = gen_table[free_slot];
        end else if (slots_used >= limit) begin
          r.status = ST_FULL;
          r.slot = '0;
        end else begin
          gen_table[slots_used] = 1;
          live_bits[slots_used] = 1'b1;
          r.slot = slots_used[IDX_W-1:0];
          r.generation = 1;
          r.appended = 1'b1;
          slots_used++;
        end
      end
      CMD_DESTROY: begin
        if (handle_valid(idx, gen)) begin
          live_bits[idx] = 1'b0;
          gen_table[idx] = (gen_table[idx] == '1) ? GEN_W'(1) : gen_table[idx] + 1'b1;
        end else begin
          r.status = ST_STALE;
        end
      end
      CMD_CHECK: r.alive = handle_valid(idx, gen);
      CMD_UNDO_SPAWN: begin
        if (app) begin
          if (slots_used == 0) begin
            r.status = ST_STALE;
          end else begin
            slots_used--;
            live_bits[slots_used] = 1'b0;
          end
        end else if (idx < slots_used && gen != '0) begin
          live_bits[idx] = 1'b0;
          gen_table[idx] = gen;
        end else begin
          r.status = ST_STALE;
        end
      end
      CMD_REDO_SPAWN: begin
        if (app) begin
          if (idx != slots_used || gen == '0) begin
            r.status = ST_STALE;
          end else if (slots_used >= SLOT_COUNT) begin
            r.status = ST_FULL;
          end else begin
            gen_table[idx] = gen;
            live_bits[idx] = 1'b1;
            slots_used++;
          end
        end else if (idx < slots_used) begin
          live_bits[idx] = 1'b1;
        end else begin
          r.status = ST_STALE;
        end
      end
      CMD_UNDO_DESTROY: begin
        if (idx < slots_used && gen != '0) begin
          gen_table[idx] = gen;
          live_bits[idx] = 1'b1;
        end else begin
          r.status = ST_STALE;
        end
      end
      default: ;
    endcase
    if (show_slot) r.generation = (idx < slots_used) ? gen_table[idx] : '0;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (n = 0; n < SLOT_COUNT; n++) begin
        gen_table[n] = 1;
        live_bits[n] = 1'b0;
      end
      slots_used = 0;
      cap_setting = CAPACITY_RESET;
      expected_results.delete();
      pending_results <= 0;
    end else begin
      if (cfg_wr_en) cap_setting = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: index %0h", m_tdata[9:0]);
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          report_field("result_index", want.slot, m_tdata[9:0]);
          report_field("result_generation", want.generation, m_tdata[41:10]);
          report_field("was_appended", want.appended, m_tdata[42]);
          report_field("handle_alive", want.alive, m_tdata[43]);
          report_field("status", want.status, m_tuser);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results = {expected_results,
                            apply_command(s_tuser, s_tdata[9:0], s_tdata[41:10], s_tdata[42])};
      end
      pending_results <= expected_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, command stimulus, result back-pressure and verdict.
// Depends on gha_pkg, generational_handle_allocator_unit and handle_allocator_checker.
module testbench;
  import gha_pkg::*;

  localparam int CYCLE_LIMIT = 900000;
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  typedef struct {
    logic [2:0] cmd;
    logic       app;
  } issued_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [47:0]      s_tdata;
  logic [2:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [47:0]      m_tdata;
  logic [1:0]       m_tuser;
  int               error_count;
  int               pending_results;

  handle_t live_handles [$];
  handle_t dead_handles [$];
  issued_t issued_q [$];
  issued_t issued;
  handle_t handle_out;
  int      results_seen = 0;
  int      used_seen = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  bit      full_seen = 1'b0;
  bit      tx_gaps_on = 1'b1;
  bit      rx_gaps_on = 1'b1;
  bit      long_hold_done = 1'b0;

  generational_handle_allocator_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  handle_allocator_checker scoreboard (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .error_count(error_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Tracks handles given out and the used count so that stimulus can form valid sequences.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready) issued_q = {issued_q, issued_t'{s_tuser, s_tdata[42]}};
      if (m_tvalid && m_tready && issued_q.size() != 0) begin
        issued = issued_q.pop_front();
        results_seen++;
        handle_out = '{m_tdata[9:0], m_tdata[41:10]};
        if (live_handles.size() > 2000) void'(live_handles.pop_front());
        if (m_tuser == ST_OK) begin
          case (issued.cmd)
            CMD_SPAWN: begin
              live_handles = {live_handles, handle_out};
              if (m_tdata[42]) used_seen = int'(m_tdata[9:0]) + 1;
            end
            CMD_UNDO_SPAWN: if (issued.app) used_seen--;
            CMD_REDO_SPAWN: begin
              live_handles = {live_handles, handle_out};
              if (issued.app) used_seen++;
            end
            CMD_UNDO_DESTROY: live_handles = {live_handles, handle_out};
            default: ;
          endcase
        end else if (issued.cmd == CMD_SPAWN && m_tuser == ST_FULL) begin
          full_seen = 1'b1;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [GEN_W-1:0] pick_generation();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return $urandom_range(1, 4);
    return $urandom;
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (rx_gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      if ($urandom_range(0, 299) == 0) rx_gaps_on = ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic [GEN_W-1:0] gen, input logic app);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {5'b0, app, gen, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (8) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_command();
    int      r;
    int      k;
    int      u;
    handle_t h;
    logic [GEN_W-1:0] g;
    r = $urandom_range(0, 99);
    h.idx = IDX_W'($urandom);
    h.gen = pick_generation();
    if (r < 30) begin
      send_command(CMD_SPAWN, h.idx, $urandom, 1'($urandom));
    end else if (r < 50) begin
      if (live_handles.size() != 0 && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        live_handles.delete(k);
        if (dead_handles.size() > 500) void'(dead_handles.pop_front());
        dead_handles = {dead_handles, h};
      end
      send_command(CMD_DESTROY, h.idx, h.gen, 1'($urandom));
    end else if (r < 65) begin
      if (live_handles.size() != 0 && $urandom_range(0, 7) != 0) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        if ($urandom_range(0, 2) == 0) h.gen = h.gen ^ (32'd1 << $urandom_range(0, 31));
      end
      send_command(CMD_CHECK, h.idx, h.gen, 1'($urandom));
    end else if (r < 72) begin
      if (dead_handles.size() != 0 && $urandom_range(0, 7) != 0) begin
        k = $urandom_range(0, dead_handles.size() - 1);
        h = dead_handles[k];
        dead_handles.delete(k);
      end
      send_command(CMD_UNDO_DESTROY, h.idx, h.gen, 1'($urandom));
    end else if (r < 80) begin
      if (live_handles.size() != 0 && $urandom_range(0, 7) != 0) begin
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        live_handles.delete(k);
        if ($urandom_range(0, 3) == 0) h.gen = pick_generation();
      end
      send_command(CMD_UNDO_SPAWN, h.idx, h.gen, 1'b0);
      if ($urandom_range(0, 4) != 0) send_command(CMD_REDO_SPAWN, h.idx, $urandom, 1'b0);
    end else if (r < 86) begin
      // The used count is known exactly only once every result is back.
      drain_results();
      u = used_seen;
      if ($urandom_range(0, 1) == 0) begin
        send_command(CMD_UNDO_SPAWN, IDX_W'($urandom), $urandom, 1'b1);
        u = (u > 0) ? u - 1 : 0;
      end
      g = pick_generation();
      send_command(CMD_REDO_SPAWN, IDX_W'(u), g, 1'b1);
    end else begin
      send_command(3'($urandom_range(0, 7)), h.idx, h.gen, 1'($urandom));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 49) == 0) tx_gaps_on = ($urandom_range(0, 3) != 0);
      random_command();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    write_capacity(CNT_W'(1));
    send_command(CMD_UNDO_SPAWN, '0, '0, 1'b1);
    send_command(CMD_SPAWN, '1, '1, 1'b1);
    send_command(CMD_SPAWN, '0, '0, 1'b0);
    send_command(CMD_CHECK, '0, 32'd1, 1'b0);
    send_command(CMD_CHECK, '0, '0, 1'b1);
    send_command(CMD_CHECK, '1, '1, 1'b0);
    send_command(CMD_DESTROY, '0, 32'd2, 1'b0);
    send_command(CMD_DESTROY, '0, 32'd1, 1'b0);
    send_command(CMD_CHECK, '0, 32'd1, 1'b0);
    send_command(CMD_SPAWN, '0, '0, 1'b0);
    send_command(CMD_UNDO_DESTROY, '0, '1, 1'b0);
    send_command(CMD_DESTROY, '0, '1, 1'b1);
    send_command(CMD_UNDO_DESTROY, '0, '0, 1'b0);
    send_command(CMD_UNDO_DESTROY, IDX_W'(5), 32'd7, 1'b0);
    send_command(CMD_UNDO_SPAWN, '0, 32'h1234_5678, 1'b0);
    send_command(CMD_REDO_SPAWN, '0, '0, 1'b0);
    send_command(CMD_REDO_SPAWN, '1, 32'd1, 1'b0);
    send_command(CMD_UNDO_SPAWN, '0, '0, 1'b0);
    send_command(CMD_UNDO_SPAWN, IDX_W'(900), 32'd5, 1'b0);
    send_command(CMD_UNDO_SPAWN, '1, '1, 1'b1);
    send_command(CMD_REDO_SPAWN, '0, '0, 1'b1);
    send_command(CMD_REDO_SPAWN, IDX_W'(1), 32'd5, 1'b1);
    send_command(CMD_REDO_SPAWN, '0, '1, 1'b1);
    send_command(CMD_UNUSED_6, IDX_W'(10'h2AA), 32'hA5A5_A5A5, 1'b1);
    send_command(CMD_UNUSED_7, IDX_W'(10'h155), 32'h5A5A_5A5A, 1'b0);

    write_capacity('0);
    send_command(CMD_SPAWN, '0, '0, 1'b0);
    send_command(CMD_DESTROY, '0, '1, 1'b0);
    send_command(CMD_SPAWN, '0, '0, 1'b0);
    send_command(CMD_SPAWN, '0, '0, 1'b0);

    write_capacity(CNT_W'(4));
    run_random(120);
    write_capacity(CNT_W'(64));
    run_random(120);

    write_capacity('1);
    full_seen = 1'b0;
    while (!full_seen) send_command(CMD_SPAWN, IDX_W'($urandom), $urandom, 1'($urandom));

    write_capacity(CAPACITY_RESET);
    run_random(120);
    write_capacity(CNT_W'($urandom_range(1, SLOT_COUNT)));
    run_random(120);

    drain_results();
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/generational_handle_allocator_unit.sv
dv/handle_allocator_checker.sv
dv/testbench.sv
